// ----- hdl/hsvrgb_pkg.sv -----
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Shared types and fixed-point constants for the converter pipeline.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

    localparam int FRAC_BITS = 12;
    localparam int COMP_W    = 13;
    localparam int HUE_W     = 16;
    localparam int TH_W      = 15;
    localparam int REM_W     = 12;
    localparam int PROD_W    = 2 * COMP_W;

    localparam logic [COMP_W-1:0] ONE = COMP_W'(1 << FRAC_BITS);

    localparam logic [HUE_W-1:0] HUE_FULL   = 16'd23040;
    localparam logic [HUE_W-1:0] HUE_FULL2  = 16'd46080;
    localparam logic [TH_W-1:0]  HUE_SECTOR = 15'd3840;

    // floor(x / 15) == (x * RECIP) >> RECIP_SHIFT for every x below 2^16
    localparam logic [15:0] RECIP       = 16'd34953;
    localparam int          RECIP_SHIFT = 19;

    typedef logic [2:0] sector_t;

    localparam sector_t SECTOR_RY = 3'd0;
    localparam sector_t SECTOR_YG = 3'd1;
    localparam sector_t SECTOR_GC = 3'd2;
    localparam sector_t SECTOR_CB = 3'd3;
    localparam sector_t SECTOR_BM = 3'd4;
    localparam sector_t SECTOR_MR = 3'd5;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [COMP_W-1:0] saturation;
        logic [COMP_W-1:0] value_level;
        logic [COMP_W-1:0] alpha_in;
    } hsvrgb_in_t;

    typedef struct packed {
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
        logic [COMP_W-1:0] alpha_out;
        logic              out_of_range;
    } hsvrgb_out_t;

    typedef struct packed {
        sector_t           sector;
        logic [REM_W-1:0]  rem;
        logic [COMP_W-1:0] sat;
        logic [COMP_W-1:0] val;
        logic [COMP_W-1:0] alpha;
        logic              oor;
    } hsvrgb_split_t;

    typedef struct packed {
        sector_t           sector;
        logic [COMP_W-1:0] val;
        logic [COMP_W-1:0] m;
        logic [COMP_W-1:0] n;
        logic [COMP_W-1:0] k;
        logic [COMP_W-1:0] alpha;
        logic              oor;
    } hsvrgb_blend_t;

endpackage

// ----- hdl/hsv_to_rgb_converter.sv -----
// ----------------------------------------------------------------------------
// HSV to RGB converter
// One pixel per request. Six register stages: hue wrap, sector split,
// fraction and v(1-s), s*f products, v(...) products, channel select.
// ----------------------------------------------------------------------------
// Takes one pixel per clock unless the output is held; the pixel runs through
// the six-stage pipeline, each stage holding at most one level of
// multiplies. Hue is in 1/64 degree units and wraps at 360 degrees;
// saturation, value and alpha are unsigned Q.12 with 4096 as 1.0. Any of
// those above 1.0 yields opaque white with out_of_range set. Each stage
// advances when it is empty or the next one takes its request, so bubbles
// close while the output is held.
module hsv_to_rgb_converter (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  hsvrgb_pkg::hsvrgb_in_t  s_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output hsvrgb_pkg::hsvrgb_out_t m_data
);
    import hsvrgb_pkg::*;

    logic          split_valid;
    logic          split_ready;
    hsvrgb_split_t split_data;
    logic          blend_valid;
    logic          blend_ready;
    hsvrgb_blend_t blend_data;

    logic          out_valid_reg;
    hsvrgb_out_t   out_data_reg;
    hsvrgb_out_t   out_data_next;

    hsvrgb_hue_split u_hue_split (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (split_valid),
        .out_ready (split_ready),
        .out_data  (split_data)
    );

    hsvrgb_blend u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (split_valid),
        .in_ready  (split_ready),
        .in_data   (split_data),
        .out_valid (blend_valid),
        .out_ready (blend_ready),
        .out_data  (blend_data)
    );

    assign blend_ready = !out_valid_reg || m_ready;

    always_comb begin
        out_data_next.alpha_out    = blend_data.alpha;
        out_data_next.out_of_range = 1'b0;
        unique case (blend_data.sector)
            SECTOR_RY: begin
                out_data_next.red   = blend_data.val;
                out_data_next.green = blend_data.k;
                out_data_next.blue  = blend_data.m;
            end
            SECTOR_YG: begin
                out_data_next.red   = blend_data.n;
                out_data_next.green = blend_data.val;
                out_data_next.blue  = blend_data.m;
            end
            SECTOR_GC: begin
                out_data_next.red   = blend_data.m;
                out_data_next.green = blend_data.val;
                out_data_next.blue  = blend_data.k;
            end
            SECTOR_CB: begin
                out_data_next.red   = blend_data.m;
                out_data_next.green = blend_data.n;
                out_data_next.blue  = blend_data.val;
            end
            SECTOR_BM: begin
                out_data_next.red   = blend_data.k;
                out_data_next.green = blend_data.m;
                out_data_next.blue  = blend_data.val;
            end
            default: begin
                out_data_next.red   = blend_data.val;
                out_data_next.green = blend_data.m;
                out_data_next.blue  = blend_data.n;
            end
        endcase
        if (blend_data.oor) begin
            out_data_next.red          = ONE;
            out_data_next.green        = ONE;
            out_data_next.blue         = ONE;
            out_data_next.alpha_out    = ONE;
            out_data_next.out_of_range = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (blend_ready) begin
            out_valid_reg <= blend_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (blend_ready) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// ----- hdl/hsvrgb_hue_split.sv -----
// ----------------------------------------------------------------------------
// Hue split
// Two stages: wrap the hue modulo 360 degrees, then find the 60-degree sector
// and the remainder inside it. Flags components above one.
// ----------------------------------------------------------------------------
module hsvrgb_hue_split (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  hsvrgb_pkg::hsvrgb_in_t    in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output hsvrgb_pkg::hsvrgb_split_t out_data
);
    import hsvrgb_pkg::*;

    logic              s1_valid_reg;
    logic [TH_W-1:0]   s1_th_reg;
    logic [TH_W-1:0]   s1_th_next;
    logic [COMP_W-1:0] s1_sat_reg;
    logic [COMP_W-1:0] s1_val_reg;
    logic [COMP_W-1:0] s1_alpha_reg;
    logic              s1_oor_reg;
    logic              s1_oor_next;
    logic              s1_ready;

    logic              s2_valid_reg;
    hsvrgb_split_t     s2_data_reg;
    hsvrgb_split_t     s2_data_next;
    logic              s2_ready;
    logic [TH_W-1:0]   s2_base;

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_comb begin
        if (in_data.hue >= HUE_FULL2) begin
            s1_th_next = TH_W'(in_data.hue - HUE_FULL2);
        end else if (in_data.hue >= HUE_FULL) begin
            s1_th_next = TH_W'(in_data.hue - HUE_FULL);
        end else begin
            s1_th_next = TH_W'(in_data.hue);
        end
        s1_oor_next = (in_data.saturation > ONE) || (in_data.value_level > ONE)
                   || (in_data.alpha_in > ONE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_ready) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_ready) begin
            s1_th_reg    <= s1_th_next;
            s1_sat_reg   <= in_data.saturation;
            s1_val_reg   <= in_data.value_level;
            s1_alpha_reg <= in_data.alpha_in;
            s1_oor_reg   <= s1_oor_next;
        end
    end

    always_comb begin
        if (s1_th_reg >= TH_W'(5 * HUE_SECTOR)) begin
            s2_data_next.sector = SECTOR_MR;
            s2_base             = TH_W'(5 * HUE_SECTOR);
        end else if (s1_th_reg >= TH_W'(4 * HUE_SECTOR)) begin
            s2_data_next.sector = SECTOR_BM;
            s2_base             = TH_W'(4 * HUE_SECTOR);
        end else if (s1_th_reg >= TH_W'(3 * HUE_SECTOR)) begin
            s2_data_next.sector = SECTOR_CB;
            s2_base             = TH_W'(3 * HUE_SECTOR);
        end else if (s1_th_reg >= TH_W'(2 * HUE_SECTOR)) begin
            s2_data_next.sector = SECTOR_GC;
            s2_base             = TH_W'(2 * HUE_SECTOR);
        end else if (s1_th_reg >= HUE_SECTOR) begin
            s2_data_next.sector = SECTOR_YG;
            s2_base             = HUE_SECTOR;
        end else begin
            s2_data_next.sector = SECTOR_RY;
            s2_base             = '0;
        end
        s2_data_next.rem   = REM_W'(s1_th_reg - s2_base);
        s2_data_next.sat   = s1_sat_reg;
        s2_data_next.val   = s1_val_reg;
        s2_data_next.alpha = s1_alpha_reg;
        s2_data_next.oor   = s1_oor_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_ready) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_ready) begin
            s2_data_reg <= s2_data_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_data  = s2_data_reg;

endmodule

// ----- hdl/hsvrgb_blend.sv -----
// ----------------------------------------------------------------------------
// Blend products
// Three multiply stages: sector fraction and v(1-s), then s*f and s(1-f),
// then v(1-sf) and v(1-s(1-f)). Every product is truncated to Q.12.
// ----------------------------------------------------------------------------
module hsvrgb_blend (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  hsvrgb_pkg::hsvrgb_split_t in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output hsvrgb_pkg::hsvrgb_blend_t out_data
);
    import hsvrgb_pkg::*;

    logic              a_valid_reg;
    logic              a_ready;
    sector_t           a_sector_reg;
    logic [COMP_W-1:0] a_f_reg;
    logic [COMP_W-1:0] a_m_reg;
    logic [COMP_W-1:0] a_sat_reg;
    logic [COMP_W-1:0] a_val_reg;
    logic [COMP_W-1:0] a_alpha_reg;
    logic              a_oor_reg;
    logic [31:0]       a_f_prod;
    logic [PROD_W-1:0] a_m_prod;

    logic              b_valid_reg;
    logic              b_ready;
    sector_t           b_sector_reg;
    logic [COMP_W-1:0] b_sf_reg;
    logic [COMP_W-1:0] b_sg_reg;
    logic [COMP_W-1:0] b_m_reg;
    logic [COMP_W-1:0] b_val_reg;
    logic [COMP_W-1:0] b_alpha_reg;
    logic              b_oor_reg;
    logic [PROD_W-1:0] b_sf_prod;
    logic [PROD_W-1:0] b_sg_prod;

    logic              c_valid_reg;
    logic              c_ready;
    hsvrgb_blend_t     c_data_reg;
    hsvrgb_blend_t     c_data_next;
    logic [PROD_W-1:0] c_n_prod;
    logic [PROD_W-1:0] c_k_prod;

    assign c_ready  = !c_valid_reg || out_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // f = rem * 4096 / 3840 = rem * 16 / 15
    assign a_f_prod = 32'({in_data.rem, 4'b0000}) * 32'(RECIP);
    assign a_m_prod = PROD_W'(in_data.val) * PROD_W'(ONE - in_data.sat);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_ready) begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready) begin
            a_sector_reg <= in_data.sector;
            a_f_reg      <= a_f_prod[RECIP_SHIFT +: COMP_W];
            a_m_reg      <= a_m_prod[FRAC_BITS +: COMP_W];
            a_sat_reg    <= in_data.sat;
            a_val_reg    <= in_data.val;
            a_alpha_reg  <= in_data.alpha;
            a_oor_reg    <= in_data.oor;
        end
    end

    assign b_sf_prod = PROD_W'(a_sat_reg) * PROD_W'(a_f_reg);
    assign b_sg_prod = PROD_W'(a_sat_reg) * PROD_W'(ONE - a_f_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_ready) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_ready) begin
            b_sector_reg <= a_sector_reg;
            b_sf_reg     <= b_sf_prod[FRAC_BITS +: COMP_W];
            b_sg_reg     <= b_sg_prod[FRAC_BITS +: COMP_W];
            b_m_reg      <= a_m_reg;
            b_val_reg    <= a_val_reg;
            b_alpha_reg  <= a_alpha_reg;
            b_oor_reg    <= a_oor_reg;
        end
    end

    assign c_n_prod = PROD_W'(b_val_reg) * PROD_W'(ONE - b_sf_reg);
    assign c_k_prod = PROD_W'(b_val_reg) * PROD_W'(ONE - b_sg_reg);

    always_comb begin
        c_data_next.sector = b_sector_reg;
        c_data_next.val    = b_val_reg;
        c_data_next.m      = b_m_reg;
        c_data_next.n      = c_n_prod[FRAC_BITS +: COMP_W];
        c_data_next.k      = c_k_prod[FRAC_BITS +: COMP_W];
        c_data_next.alpha  = b_alpha_reg;
        c_data_next.oor    = b_oor_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (c_ready) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (c_ready) begin
            c_data_reg <= c_data_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_data  = c_data_reg;

endmodule
